>>> hdl/lhgo_pkg.sv
// constants, codes and types shared by the lidar height grid occupancy block
`timescale 1ns / 1ps

package lhgo_pkg;

    localparam int GRID_ROWS     = 256;
    localparam int GRID_COLUMNS  = 512;
    localparam int CELL_CM       = 10;
    localparam int SPREAD_MIN_CM = 15;
    localparam int COLUMN_OFFSET = 300;

    localparam int CELL_TOTAL = GRID_ROWS * GRID_COLUMNS;
    localparam int ADDR_W     = $clog2(CELL_TOTAL);
    localparam int ROW_W      = $clog2(GRID_ROWS);
    localparam int COL_W      = $clog2(GRID_COLUMNS);
    localparam int GRID_IDX_W = 13;

    // floor division by CELL_CM as a multiply by a rounded-up reciprocal
    localparam int DIV_N  = 17;
    localparam int DIV_L  = $clog2(CELL_CM);
    localparam int DIV_S  = DIV_N + DIV_L;
    localparam int DIV_MW = DIV_N + 2;
    localparam int PROD_W = DIV_S + DIV_N;
    localparam longint unsigned DIV_M =
        ((longint'(1) << DIV_S) + longint'(CELL_CM) - 1) / longint'(CELL_CM);

    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 40;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [14:0] RST_ROI_HALF_WIDTH = 15'd1000;
    localparam logic [15:0] RST_ROI_X_NEAR     = 16'd0;
    localparam logic [15:0] RST_ROI_X_FAR      = 16'd5000;
    localparam logic [14:0] RST_HEIGHT_LOW     = 15'd10;
    localparam logic [14:0] RST_HEIGHT_HIGH    = 15'd300;
    localparam logic [14:0] RST_VEH_HALF_WIDTH = 15'd100;
    localparam logic [15:0] RST_VEH_X_NEAR     = 16'hFF38;
    localparam logic [15:0] RST_VEH_X_FAR      = 16'd300;

    typedef enum logic [1:0] {
        OP_POINT = 2'd0,
        OP_TEST  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        REG_ROI_HALF_WIDTH = 3'd0,
        REG_ROI_X_NEAR     = 3'd1,
        REG_ROI_X_FAR      = 3'd2,
        REG_HEIGHT_LOW     = 3'd3,
        REG_HEIGHT_HIGH    = 3'd4,
        REG_VEH_HALF_WIDTH = 3'd5,
        REG_VEH_X_NEAR     = 3'd6,
        REG_VEH_X_FAR      = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [15:0] hits;
        logic [15:0] top;
        logic [15:0] bottom;
    } cell_entry_t;

endpackage

>>> hdl/lidar_height_grid_occupancy_core.sv
// lidar height grid occupancy core: point binning, cell test and map clear
`timescale 1ns / 1ps

// Each request on the s_ channel carries an operation in s_tuser. A point request occupies
// the block for the filter compares, three passes through one shared divide-by-cell-size
// unit (half width, -y, x), index formation, then a read-modify-write of one cell in the
// grid memory; the write is skipped when the point is dropped. A test request takes one
// memory read, registered, plus any wait for the m_ side to take the previous result,
// and is the only request that returns a result. A clear request, and reset, sweep the
// grid memory one cell per cycle over all CELL_TOTAL cells (131072 at 256 x 512), during
// which s_tready stays low. Configuration writes are always taken and are meant for
// idle periods only.
module lidar_height_grid_occupancy_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    // x, y, z, cell_row, cell_column, count_threshold
    input  logic [lhgo_pkg::IN_DATA_W-1:0]      s_tdata,
    // operation
    input  logic [1:0]                          s_tuser,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // occupied, out_row, out_column, hit_count
    output logic [lhgo_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lhgo_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lhgo_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import lhgo_pkg::*;

    typedef enum logic [9:0] {
        S_CLEAR  = 10'b0000000001,
        S_IDLE   = 10'b0000000010,
        S_DIVH   = 10'b0000000100,
        S_DIVY   = 10'b0000001000,
        S_DIVX   = 10'b0000010000,
        S_INDEX  = 10'b0000100000,
        S_ADDR   = 10'b0001000000,
        S_MODIFY = 10'b0010000000,
        S_TREAD  = 10'b0100000000,
        S_TRES   = 10'b1000000000
    } state_t;

    localparam logic [PROD_W-1:0] DIV_M_C = PROD_W'(DIV_M);

    state_t state_reg, state_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic              m_tvalid_reg, m_tvalid_next;

    logic [14:0]        roi_hw_reg, roi_hw_next;
    logic signed [15:0] roi_xn_reg, roi_xn_next;
    logic signed [15:0] roi_xf_reg, roi_xf_next;
    logic [14:0]        hlo_reg, hlo_next;
    logic [14:0]        hhi_reg, hhi_next;
    logic [14:0]        veh_hw_reg, veh_hw_next;
    logic signed [15:0] veh_xn_reg, veh_xn_next;
    logic signed [15:0] veh_xf_reg, veh_xf_next;

    logic signed [15:0] x_reg, x_next;
    logic signed [15:0] y_reg, y_next;
    logic signed [15:0] z_reg, z_next;
    logic [7:0]         trow_reg, trow_next;
    logic [8:0]         tcol_reg, tcol_next;
    logic [15:0]        thr_reg, thr_next;

    logic               pass_reg, pass_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic               neg_reg, neg_next;
    logic signed [17:0] hq_reg, hq_next;
    logic signed [17:0] row_reg, row_next;
    logic signed [17:0] col_reg, col_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic               tin_reg, tin_next;

    logic        occ_reg, occ_next;
    logic [7:0]  orow_reg, orow_next;
    logic [9:0]  ocol_reg, ocol_next;
    logic [15:0] hit_reg, hit_next;

    cell_entry_t mem [CELL_TOTAL];
    cell_entry_t rd_reg;
    cell_entry_t wdata;
    logic [ADDR_W-1:0] raddr, waddr;
    logic              we;

    logic signed [17:0] div_in;
    logic [17:0]        div_abs;
    logic [DIV_N-1:0]   div_n;
    logic [DIV_N-1:0]   q_mag;
    logic signed [17:0] div_q;

    logic [16:0] ay, az;
    logic        veh_hit, roi_ok, z_ok;
    logic [GRID_IDX_W-1:0] t_row_ext, t_col_ext;
    logic        t_in;
    logic [ADDR_W-1:0] t_addr, p_addr;
    logic        p_in;
    logic signed [16:0] spread;
    logic [15:0] t_hits;
    logic [15:0] hits_inc;
    logic [15:0] top_new, bot_new;
    logic        s_acc, m_acc;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {5'b0, hit_reg, ocol_reg, orow_reg, occ_reg};
    assign s_acc     = s_tvalid && s_tready;
    assign m_acc     = m_tvalid_reg && m_tready;

    // shared divide-by-cell unit
    always_comb begin
        unique case (state_reg)
            S_DIVH:  div_in = $signed({3'b0, roi_hw_reg});
            S_DIVY:  div_in = -$signed({{2{y_reg[15]}}, y_reg});
            S_DIVX:  div_in = $signed({{2{x_reg[15]}}, x_reg});
            default: div_in = '0;
        endcase
        div_abs   = 18'(-div_in);
        div_n     = div_in[17] ? DIV_N'(div_abs + 18'(CELL_CM - 1)) : div_in[DIV_N-1:0];
        prod_next = PROD_W'(div_n) * DIV_M_C;
        neg_next  = div_in[17];
        q_mag     = prod_reg[DIV_S +: DIV_N];
        div_q     = neg_reg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
    end

    // point filter
    always_comb begin
        ay = y_reg[15] ? 17'(-$signed({y_reg[15], y_reg})) : {1'b0, y_reg};
        az = z_reg[15] ? 17'(-$signed({z_reg[15], z_reg})) : {1'b0, z_reg};
        veh_hit = (ay <= {2'b0, veh_hw_reg}) && (x_reg > veh_xn_reg) && (x_reg <= veh_xf_reg);
        roi_ok  = (ay <= {2'b0, roi_hw_reg}) && (x_reg > roi_xn_reg) && (x_reg <= roi_xf_reg);
        z_ok    = (z_reg != 16'sd0) && (az > {2'b0, hlo_reg}) && (az < {2'b0, hhi_reg});
    end

    // cell addresses
    always_comb begin
        t_row_ext = GRID_IDX_W'(trow_reg);
        t_col_ext = GRID_IDX_W'(tcol_reg);
        t_in   = (t_row_ext < GRID_IDX_W'(GRID_ROWS)) && (t_col_ext < GRID_IDX_W'(GRID_COLUMNS));
        t_addr = ADDR_W'(t_row_ext[ROW_W-1:0]) * ADDR_W'(GRID_COLUMNS)
               + ADDR_W'(t_col_ext[COL_W-1:0]);
        p_in   = !row_reg[17] && (row_reg[16:0] < 17'(GRID_ROWS))
              && !col_reg[17] && (col_reg[16:0] < 17'(GRID_COLUMNS));
        p_addr = ADDR_W'(row_reg[ROW_W-1:0]) * ADDR_W'(GRID_COLUMNS)
               + ADDR_W'(col_reg[COL_W-1:0]);
    end

    // cell update and test
    always_comb begin
        hits_inc = (rd_reg.hits == 16'hFFFF) ? rd_reg.hits : rd_reg.hits + 16'd1;
        top_new  = (z_reg > $signed(rd_reg.top)) ? z_reg : rd_reg.top;
        bot_new  = (z_reg < $signed(rd_reg.bottom)) ? z_reg : rd_reg.bottom;
        spread   = $signed({rd_reg.top[15], rd_reg.top})
                 - $signed({rd_reg.bottom[15], rd_reg.bottom});
        t_hits   = tin_reg ? rd_reg.hits : 16'd0;
    end

    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        m_tvalid_next = m_tvalid_reg;
        roi_hw_next   = roi_hw_reg;
        roi_xn_next   = roi_xn_reg;
        roi_xf_next   = roi_xf_reg;
        hlo_next      = hlo_reg;
        hhi_next      = hhi_reg;
        veh_hw_next   = veh_hw_reg;
        veh_xn_next   = veh_xn_reg;
        veh_xf_next   = veh_xf_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        z_next        = z_reg;
        trow_next     = trow_reg;
        tcol_next     = tcol_reg;
        thr_next      = thr_reg;
        pass_next     = pass_reg;
        hq_next       = hq_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        addr_next     = addr_reg;
        tin_next      = tin_reg;
        occ_next      = occ_reg;
        orow_next     = orow_reg;
        ocol_next     = ocol_reg;
        hit_next      = hit_reg;
        raddr         = p_addr;
        waddr         = addr_reg;
        wdata         = '{hits: hits_inc, top: top_new, bottom: bot_new};
        we            = 1'b0;

        if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ROI_HALF_WIDTH: roi_hw_next = cfg_data[14:0];
                REG_ROI_X_NEAR:     roi_xn_next = cfg_data;
                REG_ROI_X_FAR:      roi_xf_next = cfg_data;
                REG_HEIGHT_LOW:     hlo_next    = cfg_data[14:0];
                REG_HEIGHT_HIGH:    hhi_next    = cfg_data[14:0];
                REG_VEH_HALF_WIDTH: veh_hw_next = cfg_data[14:0];
                REG_VEH_X_NEAR:     veh_xn_next = cfg_data;
                REG_VEH_X_FAR:      veh_xf_next = cfg_data;
                default:            ;
            endcase
        end

        if (m_acc) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR: begin
                we    = 1'b1;
                waddr = clr_reg;
                wdata = '0;
                clr_next = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(CELL_TOTAL - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_acc) begin
                    x_next    = s_tdata[15:0];
                    y_next    = s_tdata[31:16];
                    z_next    = s_tdata[47:32];
                    trow_next = s_tdata[55:48];
                    tcol_next = s_tdata[64:56];
                    thr_next  = s_tdata[80:65];
                    unique case (op_t'(s_tuser))
                        OP_POINT: state_next = S_DIVH;
                        OP_TEST:  state_next = S_TREAD;
                        OP_CLEAR: begin
                            state_next = S_CLEAR;
                            clr_next   = '0;
                        end
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_DIVH: begin
                pass_next  = !veh_hit && roi_ok && z_ok;
                state_next = S_DIVY;
            end
            S_DIVY: begin
                hq_next    = div_q;
                state_next = S_DIVX;
            end
            S_DIVX: begin
                row_next   = div_q + hq_reg;
                state_next = S_INDEX;
            end
            S_INDEX: begin
                col_next   = div_q;
                state_next = S_ADDR;
            end
            S_ADDR: begin
                raddr     = p_addr;
                addr_next = p_addr;
                state_next = (pass_reg && p_in) ? S_MODIFY : S_IDLE;
            end
            S_MODIFY: begin
                we         = 1'b1;
                state_next = S_IDLE;
            end
            S_TREAD: begin
                raddr      = t_addr;
                tin_next   = t_in;
                state_next = S_TRES;
            end
            S_TRES: begin
                raddr = t_addr;
                if (!m_tvalid_reg || m_tready) begin
                    occ_next  = tin_reg && (rd_reg.hits > thr_reg)
                             && (spread > $signed(17'(SPREAD_MIN_CM)));
                    orow_next = trow_reg;
                    ocol_next = 10'(tcol_reg) + 10'(COLUMN_OFFSET);
                    hit_next  = t_hits;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            roi_hw_reg   <= RST_ROI_HALF_WIDTH;
            roi_xn_reg   <= RST_ROI_X_NEAR;
            roi_xf_reg   <= RST_ROI_X_FAR;
            hlo_reg      <= RST_HEIGHT_LOW;
            hhi_reg      <= RST_HEIGHT_HIGH;
            veh_hw_reg   <= RST_VEH_HALF_WIDTH;
            veh_xn_reg   <= RST_VEH_X_NEAR;
            veh_xf_reg   <= RST_VEH_X_FAR;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            m_tvalid_reg <= m_tvalid_next;
            roi_hw_reg   <= roi_hw_next;
            roi_xn_reg   <= roi_xn_next;
            roi_xf_reg   <= roi_xf_next;
            hlo_reg      <= hlo_next;
            hhi_reg      <= hhi_next;
            veh_hw_reg   <= veh_hw_next;
            veh_xn_reg   <= veh_xn_next;
            veh_xf_reg   <= veh_xf_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        trow_reg <= trow_next;
        tcol_reg <= tcol_next;
        thr_reg  <= thr_next;
        pass_reg <= pass_next;
        prod_reg <= prod_next;
        neg_reg  <= neg_next;
        hq_reg   <= hq_next;
        row_reg  <= row_next;
        col_reg  <= col_next;
        addr_reg <= addr_next;
        tin_reg  <= tin_next;
        occ_reg  <= occ_next;
        orow_reg <= orow_next;
        ocol_reg <= ocol_next;
        hit_reg  <= hit_next;
    end

    a_clear_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == OP_CLEAR) |=> state_reg == S_CLEAR)
        else $error("clear request did not start the sweep");

    a_result_from_test: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg) == S_TRES)
        else $error("result raised outside the test step");

    a_modify_passed: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_MODIFY |-> pass_reg && $past(state_reg) == S_ADDR)
        else $error("cell update without a passing point");

    a_sweep_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR && $past(state_reg) == S_CLEAR && $past(aresetn))
            |-> clr_reg == ADDR_W'($past(clr_reg) + 1'b1))
        else $error("clear sweep skipped a cell");

endmodule

>>> dv/testbench.sv
// testbench for the lidar height grid occupancy core: point binning, cell test and map clear
`timescale 1ns / 1ps

module testbench;
    import lhgo_pkg::*;

    typedef struct packed {
        op_t                op;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic [7:0]         row;
        logic [8:0]         col;
        logic [15:0]        threshold;
    } request_t;

    typedef struct packed {
        logic        occupied;
        logic [7:0]  row;
        logic [9:0]  col;
        logic [15:0] hits;
    } cell_report_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic [1:0]            s_tuser   = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int roi_half_cm, roi_near_cm, roi_far_cm, z_low_cm, z_high_cm;
    int veh_half_cm, veh_near_cm, veh_far_cm;

    logic [15:0]        map_hits   [CELL_TOTAL];
    logic signed [15:0] map_top    [CELL_TOTAL];
    logic signed [15:0] map_bottom [CELL_TOTAL];

    cell_report_t pending_reports [$];
    int hot_row [6];
    int hot_col [6];

    int failures        = 0;
    int requests_sent   = 0;
    int reports_checked = 0;
    int settings_used   = 0;
    bit steady_flow     = 1'b0;

    lidar_height_grid_occupancy_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 aclk = ~aclk;

    always @(negedge aclk) m_tready <= steady_flow || ($urandom_range(99) >= 7);

    function automatic int floor_cell(int a);
        int q;
        q = a / CELL_CM;
        if ((a % CELL_CM) != 0 && a < 0) q = q - 1;
        return q;
    endfunction

    function automatic void clear_map();
        for (int i = 0; i < CELL_TOTAL; i++) begin
            map_hits[i]   = '0;
            map_top[i]    = '0;
            map_bottom[i] = '0;
        end
    endfunction

    function automatic void restore_defaults();
        roi_half_cm = int'(RST_ROI_HALF_WIDTH);
        roi_near_cm = int'($signed(RST_ROI_X_NEAR));
        roi_far_cm  = int'($signed(RST_ROI_X_FAR));
        z_low_cm    = int'(RST_HEIGHT_LOW);
        z_high_cm   = int'(RST_HEIGHT_HIGH);
        veh_half_cm = int'(RST_VEH_HALF_WIDTH);
        veh_near_cm = int'($signed(RST_VEH_X_NEAR));
        veh_far_cm  = int'($signed(RST_VEH_X_FAR));
        clear_map();
    endfunction

    function automatic void bin_point(int x, int y, int z);
        int ay, az, row, col, idx;
        ay = (y < 0) ? -y : y;
        az = (z < 0) ? -z : z;
        if (ay <= veh_half_cm && x > veh_near_cm && x <= veh_far_cm) return;
        if (!(ay <= roi_half_cm && x > roi_near_cm && x <= roi_far_cm)) return;
        if (z == 0 || !(az > z_low_cm && az < z_high_cm)) return;
        row = floor_cell(-y) + roi_half_cm / CELL_CM;
        col = floor_cell(x);
        if (row < 0 || row >= GRID_ROWS || col < 0 || col >= GRID_COLUMNS) return;
        idx = row * GRID_COLUMNS + col;
        if (map_hits[idx] != 16'hFFFF) map_hits[idx] = map_hits[idx] + 16'd1;
        if (z > map_top[idx]) map_top[idx] = 16'(z);
        if (z < map_bottom[idx]) map_bottom[idx] = 16'(z);
    endfunction

    function automatic cell_report_t report_cell(logic [7:0] row, logic [8:0] col,
                                                 logic [15:0] thr);
        cell_report_t r;
        int idx, spread;
        r.occupied = 1'b0;
        r.row      = row;
        r.col      = 10'(col) + 10'(COLUMN_OFFSET);
        r.hits     = '0;
        if (int'(row) < GRID_ROWS && int'(col) < GRID_COLUMNS) begin
            idx        = int'(row) * GRID_COLUMNS + int'(col);
            spread     = int'(map_top[idx]) - int'(map_bottom[idx]);
            r.hits     = map_hits[idx];
            r.occupied = (map_hits[idx] > thr && spread > SPREAD_MIN_CM);
        end
        return r;
    endfunction

    function automatic void apply_request(request_t req);
        case (req.op)
            OP_POINT: bin_point(req.x, req.y, req.z);
            OP_TEST:  pending_reports.insert(pending_reports.size(),
                                             report_cell(req.row, req.col, req.threshold));
            OP_CLEAR: clear_map();
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (failures < 50) $display("mismatch at %0t: %s got %0d expected %0d", $realtime,
                                    what, got, want);
        failures++;
    endtask

    always @(posedge aclk) begin : check_reports
        cell_report_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_reports.size() == 0) begin
                report_mismatch("cell report with no test request waiting", m_tdata[31:0], 0);
            end else begin
                want = pending_reports.pop_front();
                reports_checked++;
                if (m_tdata[0] !== want.occupied)
                    report_mismatch("occupied", 32'(m_tdata[0]), 32'(want.occupied));
                if (m_tdata[8:1] !== want.row)
                    report_mismatch("out_row", 32'(m_tdata[8:1]), 32'(want.row));
                if (m_tdata[18:9] !== want.col)
                    report_mismatch("out_column", 32'(m_tdata[18:9]), 32'(want.col));
                if (m_tdata[34:19] !== want.hits)
                    report_mismatch("hit_count", 32'(m_tdata[34:19]), 32'(want.hits));
            end
        end
    end

    task automatic send_request(request_t req);
        if (!steady_flow) begin
            while ($urandom_range(99) < 7) begin
                s_tvalid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req.op;
        s_tdata  <= {7'd0, req.threshold, req.col, req.row, req.z, req.y, req.x};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        apply_request(req);
        requests_sent++;
        @(negedge aclk);
    endtask

    task automatic send_point(int x, int y, int z);
        request_t req;
        req = '{OP_POINT, 16'(x), 16'(y), 16'(z), 8'($urandom), 9'($urandom), 16'($urandom)};
        send_request(req);
    endtask

    task automatic send_test(int row, int col, int thr);
        request_t req;
        req = '{OP_TEST, 16'($urandom), 16'($urandom), 16'($urandom), 8'(row), 9'(col),
                16'(thr)};
        send_request(req);
    endtask

    task automatic send_other(op_t op);
        request_t req;
        req = '{op, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom), 9'($urandom),
                16'($urandom)};
        send_request(req);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(negedge aclk);
        repeat (16) @(negedge aclk);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(cfg_reg_t which, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= which;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (which)
            REG_ROI_HALF_WIDTH: roi_half_cm = int'(value[14:0]);
            REG_ROI_X_NEAR:     roi_near_cm = int'($signed(value));
            REG_ROI_X_FAR:      roi_far_cm  = int'($signed(value));
            REG_HEIGHT_LOW:     z_low_cm    = int'(value[14:0]);
            REG_HEIGHT_HIGH:    z_high_cm   = int'(value[14:0]);
            REG_VEH_HALF_WIDTH: veh_half_cm = int'(value[14:0]);
            REG_VEH_X_NEAR:     veh_near_cm = int'($signed(value));
            REG_VEH_X_FAR:      veh_far_cm  = int'($signed(value));
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic load_settings(logic [15:0] roi_half, logic [15:0] roi_near,
                                 logic [15:0] roi_far, logic [15:0] z_low, logic [15:0] z_high,
                                 logic [15:0] veh_half, logic [15:0] veh_near,
                                 logic [15:0] veh_far);
        int rlo, rhi, clo, chi;
        wait_idle();
        write_reg(REG_ROI_HALF_WIDTH, roi_half);
        write_reg(REG_ROI_X_NEAR, roi_near);
        write_reg(REG_ROI_X_FAR, roi_far);
        write_reg(REG_HEIGHT_LOW, z_low);
        write_reg(REG_HEIGHT_HIGH, z_high);
        write_reg(REG_VEH_HALF_WIDTH, veh_half);
        write_reg(REG_VEH_X_NEAR, veh_near);
        write_reg(REG_VEH_X_FAR, veh_far);
        cfg_valid <= 1'b0;
        settings_used++;
        // hot cells inside the window the region of interest can reach
        rlo = floor_cell(-roi_half_cm) + roi_half_cm / CELL_CM;
        rhi = floor_cell(roi_half_cm) + roi_half_cm / CELL_CM;
        clo = floor_cell(roi_near_cm + 1);
        chi = floor_cell(roi_far_cm);
        if (rlo < 0) rlo = 0;
        if (rhi > GRID_ROWS - 1) rhi = GRID_ROWS - 1;
        if (clo < 0) clo = 0;
        if (chi > GRID_COLUMNS - 1) chi = GRID_COLUMNS - 1;
        if (rlo > rhi) begin
            rlo = 0;
            rhi = GRID_ROWS - 1;
        end
        if (clo > chi) begin
            clo = 0;
            chi = GRID_COLUMNS - 1;
        end
        for (int i = 0; i < 6; i++) begin
            hot_row[i] = $urandom_range(rhi, rlo);
            hot_col[i] = $urandom_range(chi, clo);
        end
    endtask

    task automatic run_random_phase(int count);
        request_t req;
        int done, pick, k, negy, jitter, zlo, zhi, zmag;
        done = 0;
        while (done < count) begin
            req = '{OP_POINT, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                    9'($urandom), 16'($urandom)};
            pick = $urandom_range(99);
            k    = $urandom_range(5);
            if (pick < 55) begin
                // point aimed at a hot cell
                jitter = $urandom_range(9);
                req.x  = 16'(hot_col[k] * CELL_CM + jitter);
                jitter = $urandom_range(9);
                negy   = (hot_row[k] - roi_half_cm / CELL_CM) * CELL_CM + jitter;
                if (negy >= -32767 && negy <= 32768) req.y = 16'(-negy);
                zlo = z_low_cm + 1;
                zhi = (z_high_cm > 32768) ? 32767 : z_high_cm - 1;
                if ($urandom_range(3) == 0 && zhi > zlo + 10) zhi = zlo + 10;
                if (zlo > zhi) zmag = $urandom_range(32767, 1);
                else zmag = $urandom_range(zhi, zlo);
                if ($urandom_range(15) == 0) zmag = $urandom_range(1) ? z_low_cm : z_high_cm;
                if (zmag > 32767) zmag = 32767;
                req.z = 16'($urandom_range(1) ? -zmag : zmag);
            end else if (pick < 70) begin
                req.op = OP_POINT;
            end else if (pick < 93) begin
                req.op  = OP_TEST;
                req.row = 8'(hot_row[k]);
                req.col = 9'(hot_col[k]);
                if ($urandom_range(9) != 0) req.threshold = 16'($urandom_range(20));
            end else if (pick < 97) begin
                req.op = OP_TEST;
            end else begin
                req.op = OP_NONE;
            end
            send_request(req);
            if (req.op != OP_NONE) done++;
        end
    endtask

    task automatic test_directed_defaults();
        request_t junk;
        send_point(5, 1000, 50);
        send_point(9, 991, -50);
        send_test(0, 0, 0);
        send_test(0, 0, 1);
        send_test(0, 0, 2);
        send_point(300, 100, 50);
        send_point(301, -100, 50);
        send_point(5000, -1000, 299);
        send_point(5001, 0, 50);
        send_point(0, 500, 50);
        send_point(4000, 1001, 50);
        send_point(4000, 500, 0);
        send_point(4000, 500, 10);
        send_point(4000, 500, 300);
        send_point(4000, 500, 15);
        send_test(50, 400, 0);
        send_point(4009, 491, 16);
        send_test(50, 400, 1);
        send_point(-32768, 32767, -32768);
        send_point(32767, -32768, 32767);
        send_point(2000, -300, -299);
        junk = '1;
        send_request(junk);
        send_test(255, 511, 16'hFFFF);
        send_test(200, 500, 0);
        send_other(OP_CLEAR);
        send_test(0, 0, 0);
    endtask

    task automatic test_repeated_hits();
        steady_flow = 1'b1;
        for (int i = 0; i < 40; i++) send_point(5 + i % 5, 1000, (i % 2) ? -120 : 120);
        send_test(0, 0, 39);
        send_test(0, 0, 40);
        steady_flow = 1'b0;
    endtask

    task automatic test_wide_extremes();
        load_settings(16'hFFFF, 16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000, 16'h7FFF,
                      16'h8000);
        run_random_phase(140);
    endtask

    task automatic test_narrow_window();
        load_settings(16'd255, 16'hFFFF, 16'd2000, 16'd20, 16'd200, 16'd50, 16'hFF9C, 16'd100);
        steady_flow = 1'b1;
        run_random_phase(140);
        steady_flow = 1'b0;
    endtask

    task automatic test_tight_limits();
        load_settings(16'd7, 16'h8000, 16'd5119, 16'd5, 16'h7FFF, 16'h7FFF, 16'd4000,
                      16'h7FFF);
        run_random_phase(140);
    endtask

    initial begin
        restore_defaults();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed_defaults();
        test_repeated_hits();
        test_wide_extremes();
        test_narrow_window();
        test_tight_limits();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        $display("run covered %0d requests and %0d cell reports over %0d register settings",
                 requests_sent, reports_checked, settings_used + 1);
        $display("filters, grid edges, a map clear and repeated hits on one cell were exercised");
        if (failures == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #60_000_000;
        $display("timeout with %0d cell reports outstanding", pending_reports.size());
        $display("simulation failed");
        $finish;
    end

endmodule
